// ===== rtl/gma_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the granule map allocator.
// No dependencies; the top level and the row unit import it.
package gma_pkg;

    localparam int ENTRIES       = 1024;
    localparam int GRANULE_BYTES = 16;
    localparam int POOL_BYTES    = ENTRIES * GRANULE_BYTES;

    localparam int TAG_W        = 2;
    localparam int TAGS_PER_ROW = 16;
    localparam int ROWS         = ENTRIES / TAGS_PER_ROW;
    localparam int ROW_BITS     = TAGS_PER_ROW * TAG_W;
    localparam int POS_W        = $clog2(TAGS_PER_ROW);
    localparam int POSX_W       = POS_W + 1;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int RUN_W        = IDX_W + 1;
    localparam int GRAN_SHIFT   = $clog2(GRANULE_BYTES);

    localparam int REQ_W   = 16;
    localparam int OFF_W   = 15;
    localparam int AOFF_W  = 14;
    localparam int BYTES_W = 15;
    localparam int SUM_W   = REQ_W + 1;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_REQ   = 2'd1,
        ST_NO_SPACE   = 2'd2,
        ST_BAD_OFFSET = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RIGHT,
        S_WRITE_RD,
        S_WRITE,
        S_FREE_PREV,
        S_FREE_FIRST,
        S_CLEAR
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [REQ_W-1:0]   request_bytes;
        logic [OFF_W-1:0]   free_offset;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [AOFF_W-1:0]    alloc_offset;
        logic [BYTES_W-1:0]   freed_bytes;
    } t_result;

    // controls for the shared row unit
    typedef struct packed {
        logic [RUN_W-1:0]   carry_run;
        logic [RUN_W-1:0]   need;
        logic [TAG_W-1:0]   carry_tag;
        logic [POS_W-1:0]   lo;
        logic [POSX_W-1:0]  hi_excl;
        logic [TAG_W-1:0]   fill;
        logic [TAG_W-1:0]   match;
        logic               clear_mode;
    } t_unit_ctl;

    typedef struct packed {
        logic               hit;
        logic [POS_W-1:0]   pos;
        logic [RUN_W-1:0]   run_out;
        logic [TAG_W-1:0]   carry_tag_out;
        logic [TAG_W-1:0]   left_tag;
        logic [TAG_W-1:0]   next_tag;
        logic [POSX_W-1:0]  stop;
        logic [ROW_BITS-1:0] wdata;
    } t_unit_out;

endpackage

// ===== rtl/granule_map_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the granule map allocator: sequencer, used-byte count, map RAM.
// Depends on gma_pkg, gma_ram and gma_row_unit.
//
// Usage:
// Requests enter on i_req and are transferred at a rising edge with start high
// and busy low. busy stays high until the result is out. Each request gives
// exactly one result on o_result, shown for one cycle with o_valid high; the
// receiver cannot stall, so it must take o_result whenever o_valid is set.
// A new request may be transferred in the same cycle that o_valid is shown.
// The map is held 16 tags per RAM row (64 rows) and one row unit walks it,
// one row per cycle, through the single RAM read port.
// Steps, from transfer to o_valid:
//   zero or oversized allocate, free offset past the pool: a check only;
//   allocate: a check, a row-by-row scan, a read of the right neighbor
//   when it lies in the next row, then a tag sweep over the rows;
//   free: a check, a read of the previous tag unless the offset is zero,
//   a read of the first tag, then a clear sweep if that tag is in use.
// Reset (i_rst_n low at a clock edge) empties the map and the used count at
// once through per-row valid bits; no clearing sweep is run.
module granule_map_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  gma_pkg::t_request i_req,
    output logic              busy,
    output logic              o_valid,
    output gma_pkg::t_result  o_result
);
    import gma_pkg::*;

    t_state             r_state,    n_state;
    t_request           r_req,      n_req;
    logic [RUN_W-1:0]   r_need,     n_need;
    logic [ROW_W-1:0]   r_row,      n_row;
    logic [RUN_W-1:0]   r_run,      n_run;
    logic [TAG_W-1:0]   r_last_nz,  n_last_nz;
    logic [IDX_W-1:0]   r_start,    n_start;
    logic [IDX_W-1:0]   r_end,      n_end;
    logic [TAG_W-1:0]   r_left,     n_left;
    logic [TAG_W-1:0]   r_right,    n_right;
    logic [TAG_W-1:0]   r_id,       n_id;
    logic [TAG_W-1:0]   r_prev,     n_prev;
    logic               r_has_prev, n_has_prev;
    logic [TAG_W-1:0]   r_first,    n_first;
    logic [RUN_W-1:0]   r_count,    n_count;
    logic [BYTES_W-1:0] r_used,     n_used;
    logic               r_valid,    n_valid;
    t_result            r_result,   n_result;
    logic [ROWS-1:0]    r_row_valid;
    logic               r_rd_valid;

    logic [ROW_W-1:0]    ram_raddr;
    logic [ROW_W-1:0]    ram_waddr;
    logic                ram_we;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_q;
    logic [ROW_BITS-1:0] eff_row;

    t_unit_ctl           unit_ctl;
    t_unit_out           unit_out;

    logic [SUM_W-1:0]    used_sum;
    logic [SUM_W-1:0]    round_sum;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    prev_idx;
    logic [IDX_W-1:0]    hit_idx;
    logic [TAG_W-1:0]    first_tag;
    logic [RUN_W-1:0]    count_new;
    logic [BYTES_W-1:0]  clear_bytes;
    logic [ROW_W-1:0]    start_row;
    logic [ROW_W-1:0]    end_row;

    gma_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    gma_row_unit u_row (
        .i_row (eff_row),
        .i_ctl (unit_ctl),
        .o_res (unit_out)
    );

    // a row never written since reset reads as all free
    assign eff_row     = r_rd_valid ? ram_q : '0;
    assign used_sum    = SUM_W'(r_used) + SUM_W'(r_req.request_bytes);
    assign round_sum   = SUM_W'(r_req.request_bytes) + SUM_W'(GRANULE_BYTES - 1);
    assign free_idx    = r_req.free_offset[GRAN_SHIFT +: IDX_W];
    assign prev_idx    = free_idx - IDX_W'(1);
    assign hit_idx     = {r_row, unit_out.pos};
    assign first_tag   = eff_row[r_start[POS_W-1:0]*TAG_W +: TAG_W];
    assign count_new   = r_count + RUN_W'(unit_out.stop - {1'b0, unit_ctl.lo});
    assign clear_bytes = BYTES_W'({count_new, {GRAN_SHIFT{1'b0}}});
    assign start_row   = r_start[IDX_W-1:POS_W];
    assign end_row     = r_end[IDX_W-1:POS_W];

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_need     = r_need;
        n_row      = r_row;
        n_run      = r_run;
        n_last_nz  = r_last_nz;
        n_start    = r_start;
        n_end      = r_end;
        n_left     = r_left;
        n_right    = r_right;
        n_id       = r_id;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_first    = r_first;
        n_count    = r_count;
        n_used     = r_used;
        n_valid    = 1'b0;
        n_result   = r_result;

        ram_raddr = r_row;
        ram_waddr = r_row;
        ram_we    = 1'b0;
        ram_wdata = unit_out.wdata;

        unit_ctl.carry_run  = r_run;
        unit_ctl.need       = r_need;
        unit_ctl.carry_tag  = r_last_nz;
        unit_ctl.lo         = '0;
        unit_ctl.hi_excl    = POSX_W'(TAGS_PER_ROW);
        unit_ctl.fill       = r_id;
        unit_ctl.match      = r_first;
        unit_ctl.clear_mode = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                if (r_req.operation == OP_ALLOC) begin
                    if (r_req.request_bytes == '0) begin
                        n_valid               = 1'b1;
                        n_result.status       = ST_ZERO_REQ;
                        n_result.alloc_offset = '0;
                        n_result.freed_bytes  = '0;
                        n_state               = S_IDLE;
                    end else if (used_sum > SUM_W'(POOL_BYTES)) begin
                        n_valid               = 1'b1;
                        n_result.status       = ST_NO_SPACE;
                        n_result.alloc_offset = '0;
                        n_result.freed_bytes  = '0;
                        n_state               = S_IDLE;
                    end else begin
                        n_need    = round_sum[GRAN_SHIFT +: RUN_W];
                        n_row     = '0;
                        n_run     = '0;
                        n_last_nz = TAG_W'(1);    // left map edge acts as id 1
                        ram_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end else begin
                    if (r_req.free_offset >= OFF_W'(POOL_BYTES)) begin
                        n_valid               = 1'b1;
                        n_result.status       = ST_BAD_OFFSET;
                        n_result.alloc_offset = '0;
                        n_result.freed_bytes  = '0;
                        n_state               = S_IDLE;
                    end else begin
                        n_start = free_idx;
                        if (free_idx != '0) begin
                            n_has_prev = 1'b1;
                            ram_raddr  = prev_idx[IDX_W-1:POS_W];
                            n_state    = S_FREE_PREV;
                        end else begin
                            n_has_prev = 1'b0;
                            ram_raddr  = free_idx[IDX_W-1:POS_W];
                            n_state    = S_FREE_FIRST;
                        end
                    end
                end
            end

            S_SCAN: begin
                // fetch the next row ahead; it also holds a right neighbor
                // that falls past the end of this row
                ram_raddr = r_row + ROW_W'(1);
                if (unit_out.hit) begin
                    n_end   = hit_idx;
                    n_start = IDX_W'(RUN_W'(hit_idx) + RUN_W'(1) - r_need);
                    n_left  = unit_out.left_tag;
                    if (hit_idx == IDX_W'(ENTRIES - 1)) begin
                        n_right = TAG_W'(1);
                        n_state = S_WRITE_RD;
                    end else if (unit_out.pos == POS_W'(TAGS_PER_ROW - 1)) begin
                        n_state = S_RIGHT;
                    end else begin
                        n_right = unit_out.next_tag;
                        n_state = S_WRITE_RD;
                    end
                end else if (r_row == ROW_W'(ROWS - 1)) begin
                    n_valid               = 1'b1;
                    n_result.status       = ST_NO_SPACE;
                    n_result.alloc_offset = '0;
                    n_result.freed_bytes  = '0;
                    n_state               = S_IDLE;
                end else begin
                    n_row     = r_row + ROW_W'(1);
                    n_run     = unit_out.run_out;
                    n_last_nz = unit_out.carry_tag_out;
                end
            end

            S_RIGHT: begin
                n_right = eff_row[TAG_W-1:0];
                n_state = S_WRITE_RD;
            end

            S_WRITE_RD: begin
                ram_raddr = start_row;
                n_row     = start_row;
                if (r_left != TAG_W'(1) && r_right != TAG_W'(1)) begin
                    n_id = TAG_W'(1);
                end else if (r_left != TAG_W'(2) && r_right != TAG_W'(2)) begin
                    n_id = TAG_W'(2);
                end else begin
                    n_id = TAG_W'(3);
                end
                n_state = S_WRITE;
            end

            S_WRITE: begin
                ram_raddr = r_row + ROW_W'(1);
                unit_ctl.lo = (r_row == start_row) ? r_start[POS_W-1:0] : '0;
                unit_ctl.hi_excl = (r_row == end_row)
                                 ? POSX_W'(r_end[POS_W-1:0]) + POSX_W'(1)
                                 : POSX_W'(TAGS_PER_ROW);
                ram_we    = 1'b1;
                ram_waddr = r_row;
                if (r_row == end_row) begin
                    n_used                = r_used + BYTES_W'({r_need, {GRAN_SHIFT{1'b0}}});
                    n_valid               = 1'b1;
                    n_result.status       = ST_OK;
                    n_result.alloc_offset = AOFF_W'({r_start, {GRAN_SHIFT{1'b0}}});
                    n_result.freed_bytes  = '0;
                    n_state               = S_IDLE;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end

            S_FREE_PREV: begin
                n_prev    = eff_row[prev_idx[POS_W-1:0]*TAG_W +: TAG_W];
                ram_raddr = start_row;
                n_state   = S_FREE_FIRST;
            end

            S_FREE_FIRST: begin
                if (r_has_prev && first_tag == r_prev) begin
                    n_valid               = 1'b1;
                    n_result.status       = ST_BAD_OFFSET;
                    n_result.alloc_offset = '0;
                    n_result.freed_bytes  = '0;
                    n_state               = S_IDLE;
                end else if (first_tag == '0) begin
                    n_valid               = 1'b1;
                    n_result.status       = ST_OK;
                    n_result.alloc_offset = '0;
                    n_result.freed_bytes  = '0;
                    n_state               = S_IDLE;
                end else begin
                    n_first   = first_tag;
                    n_row     = start_row;
                    n_count   = '0;
                    ram_raddr = start_row;
                    n_state   = S_CLEAR;
                end
            end

            S_CLEAR: begin
                unit_ctl.clear_mode = 1'b1;
                unit_ctl.fill       = '0;
                unit_ctl.lo = (r_row == start_row) ? r_start[POS_W-1:0] : '0;
                ram_raddr = r_row + ROW_W'(1);
                ram_we    = 1'b1;
                ram_waddr = r_row;
                if (unit_out.stop != POSX_W'(TAGS_PER_ROW) ||
                    r_row == ROW_W'(ROWS - 1)) begin
                    n_used = (clear_bytes > r_used) ? '0 : r_used - clear_bytes;
                    n_valid               = 1'b1;
                    n_result.status       = ST_OK;
                    n_result.alloc_offset = '0;
                    n_result.freed_bytes  = clear_bytes;
                    n_state               = S_IDLE;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_count = count_new;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_used      <= '0;
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_used     <= n_used;
            r_rd_valid <= r_row_valid[ram_raddr];
            if (ram_we) begin
                r_row_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_need     <= n_need;
        r_row      <= n_row;
        r_run      <= n_run;
        r_last_nz  <= n_last_nz;
        r_start    <= n_start;
        r_end      <= n_end;
        r_left     <= n_left;
        r_right    <= n_right;
        r_id       <= n_id;
        r_prev     <= n_prev;
        r_has_prev <= n_has_prev;
        r_first    <= n_first;
        r_count    <= n_count;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_transfer_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    a_used_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used <= BYTES_W'(POOL_BYTES)) && (r_used[GRAN_SHIFT-1:0] == '0))
        else $error("used count outside pool or not granule aligned");

    a_map_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> busy)
        else $error("map written while idle");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |->
            (o_result.alloc_offset == '0 && o_result.freed_bytes == '0))
        else $error("failed request reports nonzero offset or bytes");

endmodule

// ===== rtl/gma_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gma_row_unit.sv =====
`timescale 1ns / 1ps
// Row unit: free-run search, run-end search and tag merge over one map row.
// Depends on gma_pkg.
module gma_row_unit (
    input  logic [gma_pkg::ROW_BITS-1:0] i_row,
    input  gma_pkg::t_unit_ctl           i_ctl,
    output gma_pkg::t_unit_out           o_res
);
    import gma_pkg::*;

    logic [TAG_W-1:0]        tag     [TAGS_PER_ROW];
    logic [POS_W-1:0]        last_nz [TAGS_PER_ROW];
    logic [RUN_W-1:0]        run     [TAGS_PER_ROW];
    logic [TAGS_PER_ROW-1:0] nz;
    logic [TAGS_PER_ROW-1:0] has_nz;
    logic [TAGS_PER_ROW-1:0] hit;
    logic [POS_W-1:0]        sel;
    logic [POSX_W-1:0]       stop;
    logic [POSX_W-1:0]       hi_eff;

    always_comb begin
        for (int j = 0; j < TAGS_PER_ROW; j++) begin
            tag[j] = i_row[j*TAG_W +: TAG_W];
            nz[j]  = (tag[j] != '0);
        end

        // run length ending at each slot, carried in from earlier rows
        for (int j = 0; j < TAGS_PER_ROW; j++) begin
            has_nz[j]  = 1'b0;
            last_nz[j] = '0;
            for (int k = 0; k < TAGS_PER_ROW; k++) begin
                if (k <= j && nz[k]) begin
                    has_nz[j]  = 1'b1;
                    last_nz[j] = POS_W'(k);
                end
            end
            if (nz[j]) begin
                run[j] = '0;
            end else if (has_nz[j]) begin
                run[j] = RUN_W'(j) - RUN_W'(last_nz[j]);
            end else begin
                run[j] = i_ctl.carry_run + RUN_W'(j + 1);
            end
            hit[j] = !nz[j] && (run[j] >= i_ctl.need);
        end

        sel = '0;
        for (int j = TAGS_PER_ROW - 1; j >= 0; j--) begin
            if (hit[j]) begin
                sel = POS_W'(j);
            end
        end

        // first slot at or above lo whose tag leaves the run
        stop = POSX_W'(TAGS_PER_ROW);
        for (int j = TAGS_PER_ROW - 1; j >= 0; j--) begin
            if (POS_W'(j) >= i_ctl.lo && tag[j] != i_ctl.match) begin
                stop = POSX_W'(j);
            end
        end

        hi_eff = i_ctl.clear_mode ? stop : i_ctl.hi_excl;

        for (int j = 0; j < TAGS_PER_ROW; j++) begin
            if (POSX_W'(j) >= {1'b0, i_ctl.lo} && POSX_W'(j) < hi_eff) begin
                o_res.wdata[j*TAG_W +: TAG_W] = i_ctl.fill;
            end else begin
                o_res.wdata[j*TAG_W +: TAG_W] = tag[j];
            end
        end

        o_res.hit           = |hit;
        o_res.pos           = sel;
        o_res.run_out       = run[TAGS_PER_ROW-1];
        o_res.carry_tag_out = has_nz[TAGS_PER_ROW-1] ? tag[last_nz[TAGS_PER_ROW-1]]
                                                     : i_ctl.carry_tag;
        o_res.left_tag      = has_nz[sel] ? tag[last_nz[sel]] : i_ctl.carry_tag;
        o_res.next_tag      = tag[POS_W'(sel + POS_W'(1))];
        o_res.stop          = stop;
    end

endmodule
